// ===== hw/rtl/gbsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbsrc_pkg
// Shared widths, register reset values, register indexes and the
// configuration bundle for the good/bad send rate controller.
// ----------------------------------------------------------------------------
package gbsrc_pkg;

  localparam int TIME_WIDTH_DEF = 32;

  localparam int RTT_W     = 24;
  localparam int PEN_W     = 26;
  localparam int RATE_W    = 8;
  localparam int ELAPSED_W = 20;
  localparam int OP_W      = 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  localparam logic [RTT_W-1:0]  RTT_THRESHOLD_RST = RTT_W'(250000);
  localparam logic [PEN_W-1:0]  PENALTY_INIT_RST  = PEN_W'(4000000);
  localparam logic [PEN_W-1:0]  PENALTY_MIN_RST   = PEN_W'(1000000);
  localparam logic [PEN_W-1:0]  PENALTY_MAX_RST   = PEN_W'(60000000);
  localparam logic [PEN_W-1:0]  STABLE_WINDOW_RST = PEN_W'(10000000);
  localparam logic [RATE_W-1:0] GOOD_RATE_RST     = RATE_W'(30);
  localparam logic [RATE_W-1:0] BAD_RATE_RST      = RATE_W'(10);

  // Input word kinds carried in tuser
  localparam logic [OP_W-1:0] OP_TICK    = 1'b0;
  localparam logic [OP_W-1:0] OP_RESTART = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RTT_THRESHOLD = 3'd0,
    CFG_PENALTY_INIT  = 3'd1,
    CFG_PENALTY_MIN   = 3'd2,
    CFG_PENALTY_MAX   = 3'd3,
    CFG_STABLE_WINDOW = 3'd4,
    CFG_GOOD_RATE     = 3'd5,
    CFG_BAD_RATE      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [RTT_W-1:0]  rtt_threshold_us;
    logic [PEN_W-1:0]  penalty_init_us;
    logic [PEN_W-1:0]  penalty_min_us;
    logic [PEN_W-1:0]  penalty_max_us;
    logic [PEN_W-1:0]  stable_window_us;
    logic [RATE_W-1:0] good_rate;
    logic [RATE_W-1:0] bad_rate;
  } cfg_t;

endpackage

// ===== hw/rtl/gbsrc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gbsrc_cfg_regs
// Configuration register file; takes one write word per cycle.
// ----------------------------------------------------------------------------
module gbsrc_cfg_regs
  import gbsrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rtt_threshold_us <= RTT_THRESHOLD_RST;
      cfg.penalty_init_us  <= PENALTY_INIT_RST;
      cfg.penalty_min_us   <= PENALTY_MIN_RST;
      cfg.penalty_max_us   <= PENALTY_MAX_RST;
      cfg.stable_window_us <= STABLE_WINDOW_RST;
      cfg.good_rate        <= GOOD_RATE_RST;
      cfg.bad_rate         <= BAD_RATE_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_RTT_THRESHOLD: cfg.rtt_threshold_us <= wr_data[RTT_W-1:0];
        CFG_PENALTY_INIT:  cfg.penalty_init_us  <= wr_data[PEN_W-1:0];
        CFG_PENALTY_MIN:   cfg.penalty_min_us   <= wr_data[PEN_W-1:0];
        CFG_PENALTY_MAX:   cfg.penalty_max_us   <= wr_data[PEN_W-1:0];
        CFG_STABLE_WINDOW: cfg.stable_window_us <= wr_data[PEN_W-1:0];
        CFG_GOOD_RATE:     cfg.good_rate        <= wr_data[RATE_W-1:0];
        CFG_BAD_RATE:      cfg.bad_rate         <= wr_data[RATE_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/gbsrc_update.sv =====
// ----------------------------------------------------------------------------
// gbsrc_update
// Next-state logic for one word: restart, mode switch, penalty doubling and
// halving, saturating timers.
// ----------------------------------------------------------------------------
module gbsrc_update
  import gbsrc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  cfg_t                  cfg,
  input  logic [OP_W-1:0]       op,
  input  logic [ELAPSED_W-1:0]  elapsed_us,
  input  logic [RTT_W-1:0]      rtt_us,
  input  logic                  is_good,
  input  logic [PEN_W-1:0]      penalty,
  input  logic [TIME_WIDTH-1:0] good_time,
  input  logic [TIME_WIDTH-1:0] reduce_accum,
  output logic                  is_good_next,
  output logic [PEN_W-1:0]      penalty_next,
  output logic [TIME_WIDTH-1:0] good_time_next,
  output logic [TIME_WIDTH-1:0] reduce_accum_next,
  output logic [RATE_W-1:0]     send_rate_next
);

  logic                  bad_rtt;
  logic [TIME_WIDTH:0]   gt_sum;
  logic [TIME_WIDTH:0]   ra_sum;
  logic [TIME_WIDTH-1:0] gt_sat;
  logic [TIME_WIDTH-1:0] ra_sat;
  logic [TIME_WIDTH-1:0] gt_bad;
  logic [TIME_WIDTH-1:0] window_ext;
  logic [PEN_W:0]        pen_dbl;
  logic [PEN_W-1:0]      pen_half;

  assign bad_rtt    = rtt_us > cfg.rtt_threshold_us;
  assign gt_sum     = {1'b0, good_time} + (TIME_WIDTH + 1)'(elapsed_us);
  assign ra_sum     = {1'b0, reduce_accum} + (TIME_WIDTH + 1)'(elapsed_us);
  assign gt_sat     = gt_sum[TIME_WIDTH] ? '1 : gt_sum[TIME_WIDTH-1:0];
  assign ra_sat     = ra_sum[TIME_WIDTH] ? '1 : ra_sum[TIME_WIDTH-1:0];
  assign gt_bad     = bad_rtt ? '0 : gt_sat;
  assign window_ext = TIME_WIDTH'(cfg.stable_window_us);
  assign pen_dbl    = {penalty, 1'b0};
  assign pen_half   = penalty >> 1;

  always_comb begin
    is_good_next      = is_good;
    penalty_next      = penalty;
    good_time_next    = good_time;
    reduce_accum_next = reduce_accum;
    if (op == OP_RESTART) begin
      is_good_next      = 1'b0;
      penalty_next      = cfg.penalty_init_us;
      good_time_next    = '0;
      reduce_accum_next = '0;
    end else if (is_good) begin
      if (bad_rtt) begin
        // drop to bad mode; a short good spell doubles the penalty
        is_good_next      = 1'b0;
        good_time_next    = '0;
        reduce_accum_next = '0;
        if ((good_time < window_ext) && (penalty < cfg.penalty_max_us)) begin
          penalty_next = (pen_dbl > {1'b0, cfg.penalty_max_us}) ?
                         cfg.penalty_max_us : pen_dbl[PEN_W-1:0];
        end
      end else begin
        good_time_next    = gt_sat;
        reduce_accum_next = ra_sat;
        if ((ra_sat > window_ext) && (penalty > cfg.penalty_min_us)) begin
          penalty_next      = (pen_half < cfg.penalty_min_us) ?
                              cfg.penalty_min_us : pen_half;
          reduce_accum_next = '0;
        end
      end
    end else begin
      good_time_next = gt_bad;
      if (gt_bad > TIME_WIDTH'(penalty)) begin
        good_time_next    = '0;
        reduce_accum_next = '0;
        is_good_next      = 1'b1;
      end
    end
  end

  assign send_rate_next = is_good_next ? cfg.good_rate : cfg.bad_rate;

endmodule

// ===== hw/rtl/good_bad_send_rate_control.sv =====
// ----------------------------------------------------------------------------
// good_bad_send_rate_control
// Two-mode link send rate controller with a streaming word interface.
// ----------------------------------------------------------------------------
// Takes one word per clock while the result side keeps up, and returns one
// result word for each, in order. A word passes an input register, the mode
// and penalty update, and the result register. The state registers close a
// loop through the update logic, and that loop sets the sustained rate of
// one word per cycle. Back-pressure on the result side stalls the input
// register: with the result register held, the input register takes one
// more word and then holds s_tready low. Tick words carry elapsed time and a
// round-trip time; a restart word (tuser set) clears the mode and timers and
// loads the configured initial penalty but leaves the configuration alone.
// Configuration writes are taken in any cycle and are meant to be issued
// only while no word is in flight; a new initial penalty takes effect at the
// next restart.
// ----------------------------------------------------------------------------
module good_bad_send_rate_control
  import gbsrc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [19:0] elapsed_us, [43:20] rtt_us, zero pad
  input  logic [OP_W-1:0]       s_tuser,   // [0] op: 0 tick, 1 restart
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [0] good_mode, [8:1] send_rate,
                                           // [34:9] penalty_us, zero pad
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  // input register
  logic                  in_valid;
  logic [OP_W-1:0]       in_op;
  logic [ELAPSED_W-1:0]  in_elapsed;
  logic [RTT_W-1:0]      in_rtt;

  // controller state
  logic                  is_good;
  logic [PEN_W-1:0]      penalty;
  logic [TIME_WIDTH-1:0] good_time;
  logic [TIME_WIDTH-1:0] reduce_accum;

  logic                  is_good_next;
  logic [PEN_W-1:0]      penalty_next;
  logic [TIME_WIDTH-1:0] good_time_next;
  logic [TIME_WIDTH-1:0] reduce_accum_next;
  logic [RATE_W-1:0]     send_rate_next;

  // result register
  logic                  out_valid;
  logic                  out_good;
  logic [RATE_W-1:0]     out_rate;
  logic [PEN_W-1:0]      out_penalty;

  logic                  advance;
  logic                  take_in;

  assign cfg_ready = 1'b1;

  gbsrc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held word whenever the result register is free or drains now
  assign advance  = in_valid & (~out_valid | m_tready);
  assign s_tready = ~in_valid | advance;
  assign take_in  = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take_in) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_op      <= s_tuser;
      in_elapsed <= s_tdata[ELAPSED_W-1:0];
      in_rtt     <= s_tdata[ELAPSED_W+RTT_W-1:ELAPSED_W];
    end
  end

  gbsrc_update #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_update (
    .cfg               (cfg),
    .op                (in_op),
    .elapsed_us        (in_elapsed),
    .rtt_us            (in_rtt),
    .is_good           (is_good),
    .penalty           (penalty),
    .good_time         (good_time),
    .reduce_accum      (reduce_accum),
    .is_good_next      (is_good_next),
    .penalty_next      (penalty_next),
    .good_time_next    (good_time_next),
    .reduce_accum_next (reduce_accum_next),
    .send_rate_next    (send_rate_next)
  );

  // Commit state only when the word moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      is_good      <= 1'b0;
      penalty      <= PENALTY_INIT_RST;
      good_time    <= '0;
      reduce_accum <= '0;
    end else if (advance) begin
      is_good      <= is_good_next;
      penalty      <= penalty_next;
      good_time    <= good_time_next;
      reduce_accum <= reduce_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result payload until the next word replaces it
  always_ff @(posedge clk) begin
    if (advance) begin
      out_good    <= is_good_next;
      out_rate    <= send_rate_next;
      out_penalty <= penalty_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_DATA_W - 1 - RATE_W - PEN_W)'(0), out_penalty, out_rate, out_good};

endmodule

// ===== bench/good_bad_send_rate_control_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// good_bad_send_rate_control_test
// Self-checking bench for the good/bad send rate controller. Tick and restart
// words go in through the input stream while a mirror of the link state works
// out the mode, rate and penalty that each word should report; every result
// word is compared field by field. The run walks a short opening table, then
// random traffic shaped as calm spells broken by short bursts of slow round
// trips, under several register settings including both extremes.
// ----------------------------------------------------------------------------
module good_bad_send_rate_control_test;
  import gbsrc_pkg::*;

  localparam logic [ELAPSED_W-1:0] EL_MAX  = '1;
  localparam logic [RTT_W-1:0]     RTT_MAX = '1;
  // Index past the end of the register map: the write must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
  localparam longint unsigned TIMER_MAX = (64'd1 << TIME_WIDTH_DEF) - 64'd1;

  typedef struct packed {
    logic              good_mode;
    logic [RATE_W-1:0] send_rate;
    logic [PEN_W-1:0]  penalty_us;
  } link_result_t;

  localparam link_result_t NO_PIN = '0;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [ELAPSED_W-1:0] el;
    logic [RTT_W-1:0]     rtt;
    bit                   pinned;
    link_result_t         want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [19:0] elapsed_us, [43:20] rtt_us, zero pad
  logic [OP_W-1:0]       s_tuser = OP_TICK;  // [0] op
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [0] good_mode, [8:1] send_rate,
                                         // [34:9] penalty_us, zero pad
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Sideband that travels with each word: a result typed into the opening
  // table replaces the mirror's own when the word is taken
  bit           pin_on = 1'b0;
  link_result_t pin_want = '0;

  good_bad_send_rate_control DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Link mirror: its own copy of the registers and of the mode state
  // --------------------------------------------------------------------------
  cfg_t            mirror;
  bit              link_good;
  longint unsigned link_penalty;
  longint unsigned good_spell;    // calm time in bad mode, spell length in good
  longint unsigned calm_credit;   // calm time towards the next halving

  link_result_t rate_due_q[$];    // expected result words, oldest first
  int           faults = 0;

  function automatic longint unsigned sat_time(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > TIMER_MAX) ? TIMER_MAX : s;
  endfunction

  function automatic void clear_link();
    link_good    = 1'b0;
    link_penalty = mirror.penalty_init_us;
    good_spell   = 0;
    calm_credit  = 0;
  endfunction

  function automatic link_result_t predict_link(logic [OP_W-1:0] op,
                                                logic [ELAPSED_W-1:0] el,
                                                logic [RTT_W-1:0] rtt);
    bit              hot;
    longint unsigned step;
    link_result_t    r;
    hot = rtt > mirror.rtt_threshold_us;
    if (op == OP_RESTART) begin
      clear_link();
    end else if (link_good) begin
      if (hot) begin
        // Drop to bad mode; a short good spell doubles the penalty up to the cap
        link_good = 1'b0;
        if (good_spell < mirror.stable_window_us && link_penalty < mirror.penalty_max_us) begin
          step = link_penalty << 1;
          link_penalty = (step > mirror.penalty_max_us) ? mirror.penalty_max_us : step;
        end
        good_spell  = 0;
        calm_credit = 0;
      end else begin
        good_spell  = sat_time(good_spell, el);
        calm_credit = sat_time(calm_credit, el);
        if (calm_credit > mirror.stable_window_us && link_penalty > mirror.penalty_min_us) begin
          step = link_penalty >> 1;
          link_penalty = (step < mirror.penalty_min_us) ? mirror.penalty_min_us : step;
          calm_credit  = 0;
        end
      end
    end else begin
      // Bad mode: calm time has to outlast the penalty before going good
      good_spell = hot ? 0 : sat_time(good_spell, el);
      if (good_spell > link_penalty) begin
        good_spell  = 0;
        calm_credit = 0;
        link_good   = 1'b1;
      end
    end
    r.good_mode  = link_good;
    r.send_rate  = link_good ? mirror.good_rate : mirror.bad_rate;
    r.penalty_us = link_penalty[PEN_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Watch every handshake at the rising edge: register writes update the
  // mirror, taken words queue their expected result, result words are checked
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_link
    link_result_t want;
    link_result_t seen;
    if (rst) begin
      mirror.rtt_threshold_us = RTT_THRESHOLD_RST;
      mirror.penalty_init_us  = PENALTY_INIT_RST;
      mirror.penalty_min_us   = PENALTY_MIN_RST;
      mirror.penalty_max_us   = PENALTY_MAX_RST;
      mirror.stable_window_us = STABLE_WINDOW_RST;
      mirror.good_rate        = GOOD_RATE_RST;
      mirror.bad_rate         = BAD_RATE_RST;
      clear_link();
    end else begin
      if (cfg_valid && cfg_ready) begin
        // Narrow registers keep only their low bits
        case (cfg_index)
          CFG_RTT_THRESHOLD: mirror.rtt_threshold_us = cfg_data[RTT_W-1:0];
          CFG_PENALTY_INIT:  mirror.penalty_init_us  = cfg_data[PEN_W-1:0];
          CFG_PENALTY_MIN:   mirror.penalty_min_us   = cfg_data[PEN_W-1:0];
          CFG_PENALTY_MAX:   mirror.penalty_max_us   = cfg_data[PEN_W-1:0];
          CFG_STABLE_WINDOW: mirror.stable_window_us = cfg_data[PEN_W-1:0];
          CFG_GOOD_RATE:     mirror.good_rate        = cfg_data[RATE_W-1:0];
          CFG_BAD_RATE:      mirror.bad_rate         = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = predict_link(s_tuser, s_tdata[ELAPSED_W-1:0],
                            s_tdata[ELAPSED_W+RTT_W-1:ELAPSED_W]);
        rate_due_q.push_back(pin_on ? pin_want : want);
      end
      if (m_tvalid && m_tready) begin
        seen.good_mode  = m_tdata[0];
        seen.send_rate  = m_tdata[RATE_W:1];
        seen.penalty_us = m_tdata[PEN_W+RATE_W:RATE_W+1];
        if (rate_due_q.size() == 0) begin
          $display("%0t: result word with nothing expected, got %h", $time, m_tdata);
          faults++;
        end else begin
          want = rate_due_q.pop_front();
          if (seen.good_mode !== want.good_mode) begin
            $display("%0t: good_mode expected %0d, got %0d", $time, want.good_mode,
                     seen.good_mode);
            faults++;
          end
          if (seen.send_rate !== want.send_rate) begin
            $display("%0t: send_rate expected %0d, got %0d", $time, want.send_rate,
                     seen.send_rate);
            faults++;
          end
          if (seen.penalty_us !== want.penalty_us) begin
            $display("%0t: penalty_us expected %0d, got %0d", $time, want.penalty_us,
                     seen.penalty_us);
            faults++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: stall on a changing pattern; on request hold off for a long
  // stretch so the block fills up and pushes back on its input
  // --------------------------------------------------------------------------
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_phase     = 0;

  always @(posedge clk) begin : result_sink
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 60;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(10, 80);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      rx_phase <= (rx_phase == 2) ? 0 : rx_phase + 1;
      case (rx_mode)
        0:       m_tready <= 1'b1;                          // no stalls at all
        1:       m_tready <= $urandom_range(0, 1);
        2:       m_tready <= (rx_phase != 0);               // drop one cycle in three
        default: m_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  bit              pace_on    = 1'b1;
  int              burst_left = 0;
  logic [RTT_W-1:0] thr_now   = RTT_THRESHOLD_RST;  // threshold the traffic aims at

  // Offer one word and hold it until taken; then maybe open a gap in the burst
  task automatic send_word(input logic [OP_W-1:0] op, input logic [ELAPSED_W-1:0] el,
                           input logic [RTT_W-1:0] rtt, input bit pinned,
                           input link_result_t pin);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({rtt, el});
    s_tuser  <= op;
    pin_on   <= pinned;
    pin_want <= pin;
    do @(posedge clk); while (!s_tready);
    if (pace_on) begin
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop offering and wait for every expected word to come back, plus slack
  // for the input and result registers
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (rate_due_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Keep valid raised across back-to-back writes; the caller lowers it
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_RTT_THRESHOLD) thr_now = data[RTT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] init,
                                input logic [CFG_DATA_W-1:0] pmin, input logic [CFG_DATA_W-1:0] pmax,
                                input logic [CFG_DATA_W-1:0] window,
                                input logic [CFG_DATA_W-1:0] good_r,
                                input logic [CFG_DATA_W-1:0] bad_r);
    cfg_write(CFG_RTT_THRESHOLD, thr);
    cfg_write(CFG_PENALTY_INIT, init);
    cfg_write(CFG_PENALTY_MIN, pmin);
    cfg_write(CFG_PENALTY_MAX, pmax);
    cfg_write(CFG_STABLE_WINDOW, window);
    cfg_write(CFG_GOOD_RATE, good_r);
    cfg_write(CFG_BAD_RATE, bad_r);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: calm spells of random length broken by short bursts of
  // slow round trips, with the odd restart and some words of pure noise
  task automatic run_traffic(input int words);
    int                   calm_left;
    int                   storm_left;
    logic [OP_W-1:0]      op;
    logic [ELAPSED_W-1:0] el;
    logic [RTT_W-1:0]     rtt;
    calm_left  = $urandom_range(3, 40);
    storm_left = 0;
    repeat (words) begin
      op = ($urandom_range(0, 49) == 0) ? OP_RESTART : OP_TICK;
      case ($urandom_range(0, 9))
        0:       el = '0;
        1, 2:    el = EL_MAX;
        3, 4, 5: el = ELAPSED_W'($urandom);
        default: el = ELAPSED_W'($urandom_range(0, 400000));
      endcase
      if ($urandom_range(0, 9) == 0) begin
        rtt = RTT_W'($urandom);
      end else if (storm_left != 0) begin
        storm_left--;
        rtt = (thr_now == RTT_MAX) ? RTT_W'($urandom)
                                   : RTT_W'($urandom_range(thr_now + 1, RTT_MAX));
      end else begin
        calm_left--;
        rtt = ($urandom_range(0, 7) == 0) ? thr_now : RTT_W'($urandom_range(0, thr_now));
        if (calm_left == 0) begin
          storm_left = $urandom_range(1, 3);
          calm_left  = $urandom_range(3, 40);
        end
      end
      send_word(op, el, rtt, 1'b0, NO_PIN);
    end
  endtask

  // Opening table, reset settings throughout. Rows with a typed result are
  // plain to read off: the reset state, a calm spell clearing the penalty,
  // doubling on a short good spell, restart, and halving after a long spell.
  plan_row_t opening [25] = '{
    '{OP_TICK,    20'd0,       24'd0,      1'b1, '{1'b0, 8'd10, 26'd4000000}},
    '{OP_TICK,    20'd1000000, 24'd250000, 1'b0, NO_PIN},  // equal to threshold: calm
    '{OP_TICK,    EL_MAX,      24'd0,      1'b0, NO_PIN},
    '{OP_TICK,    20'd1000000, 24'd250001, 1'b1, '{1'b0, 8'd10, 26'd4000000}},
    '{OP_TICK,    EL_MAX,      24'd0,      1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd0,      1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd0,      1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd0,      1'b1, '{1'b1, 8'd30, 26'd4000000}},
    '{OP_TICK,    20'd0,       RTT_MAX,    1'b1, '{1'b0, 8'd10, 26'd8000000}},
    '{OP_RESTART, EL_MAX,      RTT_MAX,    1'b1, '{1'b0, 8'd10, 26'd4000000}},
    '{OP_TICK,    EL_MAX,      24'd123456, 1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd123456, 1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd123456, 1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd0,      1'b1, '{1'b1, 8'd30, 26'd4000000}},
    '{OP_TICK,    EL_MAX,      24'd250000, 1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd1,      1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd65535,  1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd200000, 1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd0,      1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd131072, 1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd249999, 1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd7,      1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd100000, 1'b0, NO_PIN},
    '{OP_TICK,    EL_MAX,      24'd250000, 1'b1, '{1'b1, 8'd30, 26'd2000000}},
    '{OP_TICK,    20'd5,       24'd300000, 1'b1, '{1'b0, 8'd10, 26'd2000000}}
  };

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[r])
      send_word(opening[r].op, opening[r].el, opening[r].rtt, opening[r].pinned,
                opening[r].want);
    run_traffic(250);

    // Scaled-down timings so the mode flips often; partway through, choke
    // the result side while the input keeps offering back to back
    wait_quiet();
    apply_settings(26'd400000, 26'd1500000, 26'd300000, 26'd6000000, 26'd2500000,
                   26'($urandom_range(1, 255)), 26'($urandom_range(1, 255)));
    run_traffic(125);
    hold_reqs <= hold_reqs + 1;
    pace_on = 1'b0;
    run_traffic(40);
    pace_on = 1'b1;
    run_traffic(85);

    // Low extremes: zero threshold, every penalty and rate at one
    wait_quiet();
    apply_settings(26'd0, 26'd1, 26'd1, 26'd1, 26'd1, 26'd1, 26'd1);
    send_word(OP_RESTART, '0, '0, 1'b0, NO_PIN);
    run_traffic(120);

    // High extremes, minimum penalty at one, upper bits set; narrow registers mask them
    wait_quiet();
    apply_settings('1, '1, 26'd1, '1, '1, '1, 26'h3FFFF80);
    send_word(OP_RESTART, EL_MAX, RTT_MAX, 1'b0, NO_PIN);
    run_traffic(150);

    // Zero penalties and rates are passed through as written; a write past
    // the register map must leave everything alone
    wait_quiet();
    cfg_write(CFG_NO_REG, '1);
    apply_settings(26'd100000, 26'd0, 26'd0, 26'd0, 26'($urandom_range(1, 5000000)),
                   26'd0, 26'd0);
    send_word(OP_RESTART, '0, '0, 1'b0, NO_PIN);
    run_traffic(100);

    // Random settings; without a restart the new initial penalty waits
    repeat (3) begin
      wait_quiet();
      apply_settings(26'($urandom_range(0, RTT_MAX)), 26'($urandom_range(1, 8000000)),
                     26'($urandom_range(1, 3000000)), 26'($urandom_range(1, 26'h3FFFFFF)),
                     26'($urandom_range(1, 20000000)), 26'($urandom_range(0, 255)),
                     26'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1)
        send_word(OP_RESTART, '0, '0, 1'b0, NO_PIN);
      run_traffic(60);
    end
    wait_quiet();

    if (faults == 0 && rate_due_q.size() == 0) begin
      $display("good_bad_send_rate_control_test OK");
    end else begin
      $display("good_bad_send_rate_control_test NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #5000000;
    $display("%0t: timed out with %0d result words outstanding", $time, rate_due_q.size());
    $display("good_bad_send_rate_control_test NOT OK");
    $finish;
  end

endmodule
